@@ rtl/hermite_sample_rate_converter_top_assert.svh @@
`ifndef HERMITE_SAMPLE_RATE_CONVERTER_TOP_ASSERT_SVH
`define HERMITE_SAMPLE_RATE_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define HSRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hsrc_pkg.sv @@
package hsrc_pkg;

	localparam int SAMPLE_W     = 24;
	localparam int MAX_CHANNELS = 2;
	localparam int TDATA_W      = MAX_CHANNELS * SAMPLE_W;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	localparam int STEP_W      = 21;
	localparam int PHASE_W     = 21;
	localparam int MU_W        = 16;
	localparam int CC_W        = 2;
	localparam int TB_W        = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	localparam logic [PHASE_W-1:0] ONE_Q16  = PHASE_W'(65536);
	localparam logic [STEP_W-1:0]  STEP_MAX = STEP_W'(1048576);
	localparam int Q14_ONE = 16384;

	// tangent path
	localparam int C_W    = 34;
	localparam int D_W    = SAMPLE_W + 1;
	localparam int TP_W   = D_W + C_W;
	localparam int TS_W   = TP_W + 1;
	localparam int TAN_SH = 29;
	localparam int TAN_W  = 30;
	localparam logic [TS_W-1:0] TAN_RND = TS_W'(1) << (TAN_SH - 1);

	// basis coefficients
	localparam int AW_W = 36;
	localparam int A_W  = 34;
	localparam logic [AW_W-1:0] ONE_Q32 = AW_W'(1) << (2 * MU_W);

	// output accumulation
	localparam int P_W    = A_W + TAN_W;
	localparam int ACC_W  = P_W + 2;
	localparam int OUT_SH = 32;
	localparam logic [ACC_W-1:0] OUT_RND = ACC_W'(1) << (OUT_SH - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 << (SAMPLE_W - 1)));

	typedef enum logic [1:0] {
		REG_RATE_STEP,
		REG_CHANNEL_COUNT,
		REG_TENSION,
		REG_BIAS
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAN_MUL,
		ST_TAN_SUM,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic            valid;
		logic            last;
		logic [MU_W-1:0] mu;
	} issue_t;

	typedef struct packed {
		logic           valid;
		logic           last;
		logic [A_W-1:0] a0;
		logic [A_W-1:0] a1;
		logic [A_W-1:0] a2;
		logic [A_W-1:0] a3;
	} coef_t;

	typedef struct packed {
		logic load;
		logic tan_mul;
		logic tan_sum;
		logic shift;
	} lane_ctrl_t;

endpackage

@@ rtl/hsrc_coef.sv @@
module hsrc_coef (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  hsrc_pkg::issue_t issue,
	output hsrc_pkg::coef_t  coef,
	output logic            busy
);
	import hsrc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;
	logic [MU_W-1:0] mu_s1, mu_s2;
	logic [2*MU_W-1:0] mu2_s1, mu2_s2;
	logic [3*MU_W-1:0] mu3p_s2;
	logic [A_W-1:0] a0_s3, a1_s3, a2_s3, a3_s3;

	logic [2*MU_W-1:0] mu3;
	logic signed [AW_W-1:0] e1, e2, e3;
	logic signed [AW_W-1:0] a0w, a1w, a2w, a3w;

	assign mu3 = (2*MU_W)'((mu3p_s2 + (3*MU_W)'(1 << (MU_W - 1))) >> MU_W);
	assign e1 = AW_W'(mu_s2);
	assign e2 = AW_W'(mu2_s2);
	assign e3 = AW_W'(mu3);

	assign a0w = (e3 <<< 1) - (e2 <<< 1) - e2 + ONE_Q32;
	assign a1w = e3 - (e2 <<< 1) + (e1 <<< MU_W);
	assign a2w = e3 - e2;
	assign a3w = (e2 <<< 1) + e2 - (e3 <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mu_s1   <= issue.mu;
			last_s1 <= issue.last;
			mu2_s1  <= issue.mu * issue.mu;
			mu_s2   <= mu_s1;
			last_s2 <= last_s1;
			mu2_s2  <= mu2_s1;
			mu3p_s2 <= mu2_s1 * mu_s1;
			last_s3 <= last_s2;
			a0_s3   <= a0w[A_W-1:0];
			a1_s3   <= a1w[A_W-1:0];
			a2_s3   <= a2w[A_W-1:0];
			a3_s3   <= a3w[A_W-1:0];
		end
	end

	assign coef.valid = v_s3;
	assign coef.last  = last_s3;
	assign coef.a0    = a0_s3;
	assign coef.a1    = a1_s3;
	assign coef.a2    = a2_s3;
	assign coef.a3    = a3_s3;
	assign busy       = v_s1 | v_s2 | v_s3;

endmodule

@@ rtl/hsrc_lane.sv @@
module hsrc_lane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  hsrc_pkg::lane_ctrl_t                   ctrl,
	input  logic signed [hsrc_pkg::SAMPLE_W-1:0]   sample,
	input  logic signed [hsrc_pkg::C_W-1:0]        c1,
	input  logic signed [hsrc_pkg::C_W-1:0]        c2,
	input  hsrc_pkg::coef_t                        coef,
	output logic signed [hsrc_pkg::SAMPLE_W-1:0]   result
);
	import hsrc_pkg::*;

	logic signed [SAMPLE_W-1:0] tap_q [4];
	logic signed [SAMPLE_W-1:0] fresh_q;
	logic signed [TP_W-1:0] tp_q [4];
	logic signed [TAN_W-1:0] m0_q, m1_q;
	logic signed [P_W-1:0] p_s4 [4];

	logic signed [D_W-1:0] d10, d21, d32;
	logic signed [TS_W-1:0] ts0, ts1;
	logic signed [A_W-1:0] a0, a1, a2, a3;
	logic signed [ACC_W-1:0] acc, scaled;

	assign d10 = D_W'(tap_q[1]) - D_W'(tap_q[0]);
	assign d21 = D_W'(tap_q[2]) - D_W'(tap_q[1]);
	assign d32 = D_W'(tap_q[3]) - D_W'(tap_q[2]);

	assign ts0 = TS_W'(tp_q[0]) + TS_W'(tp_q[1]) + TAN_RND;
	assign ts1 = TS_W'(tp_q[2]) + TS_W'(tp_q[3]) + TAN_RND;

	assign a0 = coef.a0;
	assign a1 = coef.a1;
	assign a2 = coef.a2;
	assign a3 = coef.a3;

	// history window, tap 0 oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tap_q[i] <= '0;
			end
		end else if (ctrl.shift) begin
			tap_q[0] <= tap_q[1];
			tap_q[1] <= tap_q[2];
			tap_q[2] <= tap_q[3];
			tap_q[3] <= fresh_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			fresh_q <= sample;
		end
		if (ctrl.tan_mul) begin
			tp_q[0] <= d10 * c1;
			tp_q[1] <= d21 * c2;
			tp_q[2] <= d21 * c1;
			tp_q[3] <= d32 * c2;
		end
		if (ctrl.tan_sum) begin
			m0_q <= TAN_W'(ts0 >>> TAN_SH);
			m1_q <= TAN_W'(ts1 >>> TAN_SH);
		end
		if (advance) begin
			p_s4[0] <= a0 * tap_q[1];
			p_s4[1] <= a1 * m0_q;
			p_s4[2] <= a2 * m1_q;
			p_s4[3] <= a3 * tap_q[2];
		end
	end

	assign acc = ACC_W'(p_s4[0]) + ACC_W'(p_s4[1]) + ACC_W'(p_s4[2]) + ACC_W'(p_s4[3])
		+ OUT_RND;
	assign scaled = acc >>> OUT_SH;

	always_comb begin
		if (scaled > SAT_HI) begin
			result = SAT_HI[SAMPLE_W-1:0];
		end else if (scaled < SAT_LO) begin
			result = SAT_LO[SAMPLE_W-1:0];
		end else begin
			result = scaled[SAMPLE_W-1:0];
		end
	end

endmodule

@@ rtl/hsrc_ctrl.sv @@
module hsrc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          advance,
	input  logic                          busy,
	input  logic [hsrc_pkg::STEP_W-1:0]   step,
	output logic                          s_tready,
	output hsrc_pkg::issue_t              issue,
	output hsrc_pkg::lane_ctrl_t          lane_ctrl
);
	import hsrc_pkg::*;

	state_t state_q, state_d;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0] cnt_q;

	logic more;
	logic issue_valid;
	logic [PHASE_W:0] phase_sum;

	assign more = (phase_q < ONE_Q16) && (cnt_q < CNT_W'(MAX_RESULTS));
	assign phase_sum = (PHASE_W+1)'(phase_q) + (PHASE_W+1)'(step);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_TAN_MUL;
			ST_TAN_MUL: state_d = ST_TAN_SUM;
			ST_TAN_SUM: state_d = ST_ISSUE;
			ST_ISSUE: if (!more) state_d = ST_DRAIN;
			ST_DRAIN: if (!busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		lane_ctrl   = '0;
		issue_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				lane_ctrl.load = s_tvalid;
			end
			ST_TAN_MUL: lane_ctrl.tan_mul = 1'b1;
			ST_TAN_SUM: lane_ctrl.tan_sum = 1'b1;
			ST_ISSUE: issue_valid = more & advance;
			ST_DRAIN: lane_ctrl.shift = !busy;
			default: s_tready = 1'b0;
		endcase
	end

	assign issue.valid = issue_valid;
	assign issue.mu    = phase_q[MU_W-1:0];
	assign issue.last  = (phase_sum >= (PHASE_W+1)'(ONE_Q16))
		|| (cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end
			if (issue_valid) begin
				phase_q <= phase_sum[PHASE_W-1:0];
				cnt_q   <= cnt_q + CNT_W'(1);
			end else if (state_q == ST_ISSUE && !more) begin
				phase_q <= (phase_q >= ONE_Q16) ? phase_q - ONE_Q16 : '0;
			end
		end
	end

endmodule

@@ rtl/hermite_sample_rate_converter_top.sv @@
// channel   dir   payload
// apb       in    rate_step, channel_count, tension, bias at 0x0, 0x4, 0x8, 0xc
// s_axis    in    left_sample, right_sample
// m_axis    out   left_out, right_out, last on m_tlast
//
// an input giving n output beats passes the tangent multiply and sum states,
// then issues once per beat, and the three-stage coefficient pipeline drains
// before the history window shifts
// both channel lanes compute in parallel, so mono and stereo cost the same
// m_tready low on a held beat stalls the pipeline; the output register holds it
// arst_n clears window and phase, resets configuration at once, no clearing pass
module hermite_sample_rate_converter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsrc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hsrc_pkg::DATA_W-1:0]   pwdata,
	output logic [hsrc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// left_sample [23:0], right_sample [47:24]
	input  logic [hsrc_pkg::TDATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// left_out [23:0], right_out [47:24]
	output logic [hsrc_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);
	import hsrc_pkg::*;

	logic [STEP_W-1:0] rate_step_q;
	logic [CC_W-1:0] channel_count_q;
	logic [TB_W-1:0] tension_q;
	logic [TB_W-1:0] bias_q;
	logic signed [C_W-1:0] c1_q, c2_q;

	logic [STEP_W-1:0] step;
	logic stereo;
	logic signed [TB_W:0] ob, mb, mt;
	logic advance;
	logic busy;
	issue_t issue;
	coef_t coef;
	lane_ctrl_t lane_ctrl;
	logic signed [SAMPLE_W-1:0] sample_l, sample_r, res_l, res_r;

	logic v_s4, last_s4;
	logic m_tvalid_q, m_tlast_q;
	logic [TDATA_W-1:0] m_tdata_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_step_q     <= STEP_W'(65536);
			channel_count_q <= CC_W'(1);
			tension_q       <= '0;
			bias_q          <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_RATE_STEP: rate_step_q <= pwdata[STEP_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[CC_W-1:0];
				REG_TENSION: tension_q <= pwdata[TB_W-1:0];
				REG_BIAS: bias_q <= pwdata[TB_W-1:0];
				default: rate_step_q <= rate_step_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_RATE_STEP: prdata = DATA_W'(rate_step_q);
			REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count_q);
			REG_TENSION: prdata = DATA_W'(tension_q);
			REG_BIAS: prdata = DATA_W'(bias_q);
			default: prdata = '0;
		endcase
	end

	assign step   = (rate_step_q > STEP_MAX) ? STEP_MAX : rate_step_q;
	assign stereo = channel_count_q[1];

	assign ob = (TB_W+1)'(Q14_ONE) + (TB_W+1)'(signed'(bias_q));
	assign mb = (TB_W+1)'(Q14_ONE) - (TB_W+1)'(signed'(bias_q));
	assign mt = (TB_W+1)'(Q14_ONE) - (TB_W+1)'(signed'(tension_q));

	// tangent weights are registered products of the tension and bias registers
	always_ff @(posedge clk) begin
		c1_q <= ob * mt;
		c2_q <= mb * mt;
	end

	assign advance = !m_tvalid_q || m_tready;

	hsrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.advance   (advance),
		.busy      (busy),
		.step      (step),
		.s_tready  (s_tready),
		.issue     (issue),
		.lane_ctrl (lane_ctrl)
	);

	hsrc_coef u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.issue   (issue),
		.coef    (coef),
		.busy    (busy)
	);

	assign sample_l = s_tdata[SAMPLE_W-1:0];
	assign sample_r = stereo ? s_tdata[2*SAMPLE_W-1:SAMPLE_W] : '0;

	hsrc_lane u_lane_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ctrl    (lane_ctrl),
		.sample  (sample_l),
		.c1      (c1_q),
		.c2      (c2_q),
		.coef    (coef),
		.result  (res_l)
	);

	hsrc_lane u_lane_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ctrl    (lane_ctrl),
		.sample  (sample_r),
		.c1      (c1_q),
		.c2      (c2_q),
		.coef    (coef),
		.result  (res_r)
	);

	// merge lanes into the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			v_s4       <= coef.valid;
			m_tvalid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s4   <= coef.last;
			m_tlast_q <= last_s4;
			m_tdata_q <= {stereo ? res_r : '0, res_l};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ rtl/hsrc_checker.sv @@
`include "hermite_sample_rate_converter_top_assert.svh"

module hsrc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [hsrc_pkg::ADDR_W-1:0]   paddr,
	input logic [hsrc_pkg::DATA_W-1:0]   pwdata,
	input logic [hsrc_pkg::DATA_W-1:0]   prdata,
	input logic                          pready,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [hsrc_pkg::TDATA_W-1:0]  s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hsrc_pkg::TDATA_W-1:0]  m_tdata,
	input logic                          m_tlast
);
	import hsrc_pkg::*;

	logic in_beat;
	logic rate_write;

	assign in_beat    = s_tvalid && s_tready;
	assign rate_write = psel && penable && pwrite && (paddr[3:2] == REG_RATE_STEP);

	`HSRC_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")

	`HSRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

	`HSRC_ASSERT_NEXT(a_one_item, in_beat, !s_tready, "second input taken before first finished")

	`HSRC_ASSERT_NEXT(a_rate_readback, rate_write, (paddr[3:2] != REG_RATE_STEP) || (prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0])), "rate_step readback mismatch")

endmodule

bind hermite_sample_rate_converter_top hsrc_checker u_checker (.*);
